/* sv/u8ci_pkg.sv */
// Package for the UTF-8 decoder with character index: payload types, code point
// constants, lead byte classes and the non-spacing range table.
// No dependencies.
package u8ci_pkg;

   localparam int CODE_POINT_BITS = 21;
   localparam int CHAR_INDEX_BITS = 16;

   localparam logic [CODE_POINT_BITS-1:0] REPLACEMENT_CP     = 21'h00FFFD;
   localparam logic [CODE_POINT_BITS-1:0] ZWJ_CP             = 21'h00200D;
   localparam logic [CODE_POINT_BITS-1:0] SUPPLEMENTARY_BASE = 21'h010000;

   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_MATCH = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_MATCH = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_MATCH = 8'hF0;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_INVALID
   } lead_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       span_end;
   } req_payload_type;

   typedef struct packed {
      logic [CODE_POINT_BITS-1:0] code_point;
      logic                       non_spacing;
      logic                       joins_previous;
      logic [CHAR_INDEX_BITS-1:0] char_index;
      logic                       span_last;
   } rsp_payload_type;

   // Decoder to indexer: a code point is ready this cycle
   typedef struct packed {
      logic                       produce;
      logic [CODE_POINT_BITS-1:0] code_point;
   } dec_result_type;

   // Indexer to top: classification of the emitted code point
   typedef struct packed {
      logic non_spacing;
      logic joins_previous;
   } idx_class_type;

   function automatic lead_type classify_lead(input logic [7:0] b);
      lead_type lead;
      if (!b[7]) begin
         lead = LEAD_ASCII;
      end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
         lead = LEAD_TWO;
      end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
         lead = LEAD_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
         lead = LEAD_FOUR;
      end else begin
         lead = LEAD_INVALID;
      end
      return lead;
   endfunction

   function automatic logic in_span(input logic [CODE_POINT_BITS-1:0] c,
                                    input logic [CODE_POINT_BITS-1:0] lo,
                                    input logic [CODE_POINT_BITS-1:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   // Combining marks, ZWNJ, ZWJ, CGJ and variation selectors
   function automatic logic is_non_spacing(input logic [CODE_POINT_BITS-1:0] c);
      return in_span(c, 21'h000300, 21'h00036F) || in_span(c, 21'h000483, 21'h000489) ||
             in_span(c, 21'h000591, 21'h0005C7) || in_span(c, 21'h000610, 21'h00061A) ||
             in_span(c, 21'h00064B, 21'h00065F) || (c == 21'h000670) ||
             in_span(c, 21'h0006D6, 21'h0006ED) || in_span(c, 21'h000730, 21'h00074A) ||
             (c == 21'h000E31) || in_span(c, 21'h000E34, 21'h000E3A) ||
             (c == 21'h000EB1) || in_span(c, 21'h000EB4, 21'h000EBC) ||
             in_span(c, 21'h001AB0, 21'h001AFF) || in_span(c, 21'h001DC0, 21'h001DFF) ||
             in_span(c, 21'h0020D0, 21'h0020FF) || in_span(c, 21'h00FE20, 21'h00FE2F) ||
             (c == 21'h00200C) || (c == ZWJ_CP) || (c == 21'h00034F) ||
             in_span(c, 21'h00FE00, 21'h00FE0F) || in_span(c, 21'h0E0100, 21'h0E01EF);
   endfunction

endpackage

/* sv/u8ci_if.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
// Depends on u8ci_pkg.
interface u8ci_req_if import u8ci_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface u8ci_rsp_if import u8ci_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/u8ci_decode.sv */
// UTF-8 sequence assembly: lead byte decode, continuation merge, truncation.
// Depends on u8ci_pkg.
module u8ci_decode import u8ci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  logic [7:0]     data_byte,
   input  logic           span_end,
   output dec_result_type result
);

   logic [CODE_POINT_BITS-1:0] partial_ff, partial_in;
   logic [1:0]                 left_ff, left_in;
   logic [1:0]                 left_dec;
   logic [CODE_POINT_BITS-1:0] cont_bits;
   logic [CODE_POINT_BITS-1:0] merged;
   lead_type                   lead;

   assign lead     = classify_lead(data_byte);
   assign left_dec = left_ff - 2'd1;
   assign merged   = partial_ff | cont_bits;

   always_comb begin
      case (left_dec)
         2'd0:    cont_bits = {15'b0, data_byte[5:0]};
         2'd1:    cont_bits = {9'b0, data_byte[5:0], 6'b0};
         default: cont_bits = {3'b0, data_byte[5:0], 12'b0};
      endcase
   end

   always_comb begin
      partial_in = partial_ff;
      left_in    = left_ff;
      result     = '{produce: 1'b0, code_point: '0};
      if (left_ff == 2'd0) begin
         unique case (lead)
            LEAD_ASCII: begin
               result = '{produce: 1'b1, code_point: {13'b0, data_byte}};
            end
            LEAD_TWO: begin
               partial_in = {10'b0, data_byte[4:0], 6'b0};
               left_in    = 2'd1;
            end
            LEAD_THREE: begin
               partial_in = {5'b0, data_byte[3:0], 12'b0};
               left_in    = 2'd2;
            end
            LEAD_FOUR: begin
               partial_in = {data_byte[2:0], 18'b0};
               left_in    = 2'd3;
            end
            default: begin
               result = '{produce: 1'b1, code_point: REPLACEMENT_CP};
            end
         endcase
      end else begin
         left_in = left_dec;
         if (left_dec == 2'd0) begin
            result     = '{produce: 1'b1, code_point: merged};
            partial_in = '0;
         end else begin
            partial_in = merged;
         end
      end
      // cut-short sequence at span end
      if (!result.produce && span_end) begin
         result = '{produce: 1'b1, code_point: REPLACEMENT_CP};
      end
      if (span_end) begin
         partial_in = '0;
         left_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         left_ff    <= 2'd0;
      end else if (fire) begin
         partial_ff <= partial_in;
         left_ff    <= left_in;
      end
   end

endmodule

/* sv/u8ci_index.sv */
// Non-spacing classification, ZWJ joining and saturating UTF-16 unit index.
// Depends on u8ci_pkg.
module u8ci_index import u8ci_pkg::*; #(
   parameter int IndexBits = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       emit,
   input  logic                       clear,
   input  logic [CODE_POINT_BITS-1:0] code_point,
   output idx_class_type              cls,
   output logic [CHAR_INDEX_BITS-1:0] char_index
);

   logic                               prev_zwj_ff;
   logic                               first_ff;
   logic [IndexBits-1:0]               index_ff;
   logic [IndexBits-1:0]               index_in;
   logic [1:0]                         step;
   logic [IndexBits:0]                 sum;
   logic [IndexBits+CHAR_INDEX_BITS-1:0] wide_index;

   assign cls.non_spacing    = is_non_spacing(code_point);
   assign cls.joins_previous = cls.non_spacing || prev_zwj_ff;

   assign step = (code_point >= SUPPLEMENTARY_BASE) ? 2'd2 : 2'd1;
   assign sum  = {1'b0, index_ff} + {{(IndexBits-1){1'b0}}, step};

   always_comb begin
      index_in = index_ff;
      if (!cls.joins_previous && !first_ff) begin
         index_in = sum[IndexBits] ? {IndexBits{1'b1}} : sum[IndexBits-1:0];
      end
   end

   assign wide_index = {{CHAR_INDEX_BITS{1'b0}}, index_in};
   assign char_index = wide_index[CHAR_INDEX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         prev_zwj_ff <= 1'b0;
         first_ff    <= 1'b1;
         index_ff    <= '0;
      end else if (emit) begin
         prev_zwj_ff <= (code_point == ZWJ_CP);
         first_ff    <= 1'b0;
         index_ff    <= index_in;
      end
   end

endmodule

/* sv/utf8_cluster_indexer.sv */
// Top level: byte input register, UTF-8 decode, indexing and result register.
// Depends on u8ci_pkg, u8ci_if, u8ci_decode and u8ci_index.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    data_byte[7:0], span_end
//   rsp_chan  out  valid/ready    code_point[20:0], non_spacing, joins_previous,
//                                 char_index[15:0], span_last
//
// One byte per cycle sustained while rsp_chan is not stalled; a code point passes
// the input register, then the result register, after the byte that completes it.
// Decode and index state advance when the byte leaves the input register.
// Synchronous reset clears both registers' valid flags and all span state.
// A stalled rsp_chan holds its item; the input register keeps taking bytes
// that produce nothing, and fills up otherwise.
module utf8_cluster_indexer import u8ci_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   u8ci_req_if.sink   req_chan,
   u8ci_rsp_if.source rsp_chan
);

   logic                       in_valid_ff;
   req_payload_type            in_payload_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff;
   logic                       out_free;
   logic                       advance;
   dec_result_type             dec;
   idx_class_type              cls;
   logic [CHAR_INDEX_BITS-1:0] char_index;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!dec.produce || out_free);

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   u8ci_decode decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .data_byte (in_payload_ff.data_byte),
      .span_end  (in_payload_ff.span_end),
      .result    (dec)
   );

   u8ci_index #(
      .IndexBits (INDEX_BITS)
   ) index (
      .clock      (clock),
      .reset      (reset),
      .emit       (advance && dec.produce),
      .clear      (advance && in_payload_ff.span_end),
      .code_point (dec.code_point),
      .cls        (cls),
      .char_index (char_index)
   );

   assign rsp_valid_in = (advance && dec.produce) || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_payload_ff <= req_chan.payload;
      end
      if (advance && dec.produce) begin
         rsp_payload_ff.code_point     <= dec.code_point;
         rsp_payload_ff.non_spacing    <= cls.non_spacing;
         rsp_payload_ff.joins_previous <= cls.joins_previous;
         rsp_payload_ff.char_index     <= char_index;
         rsp_payload_ff.span_last      <= in_payload_ff.span_end;
      end
   end

endmodule

/* sv/u8ci_checker.sv */
// Port-level assertions for utf8_cluster_indexer, attached with bind.
// Depends on u8ci_pkg.
module u8ci_checker import u8ci_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.non_spacing |-> rsp_payload.joins_previous)
      else $error("non-spacing item not marked as joined");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.code_point == ZWJ_CP |-> rsp_payload.non_spacing)
      else $error("ZWJ not classified as non-spacing");

endmodule

bind utf8_cluster_indexer u8ci_checker checker_inst (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* tb/sv/u8ci_decode_checker.sv */
// Watches both channels of the UTF-8 decoder, predicts each code point with
// its class and character index, and compares every item that leaves the block.
// Depends on u8ci_pkg.
`timescale 1ns / 100ps
module u8ci_decode_checker import u8ci_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              mismatches,
   output int              codes_due
);

   // Decoder state as the block should hold it
   logic [CODE_POINT_BITS-1:0] pend_bits;
   logic [1:0]                 pend_count;
   logic                       after_zwj;
   logic                       span_fresh;
   logic [INDEX_BITS-1:0]      char_pos;

   rsp_payload_type code_points_due[$];
   rsp_payload_type oldest;

   function automatic logic is_mark(input logic [CODE_POINT_BITS-1:0] c);
      logic hit;
      hit = (c >= 21'h000300 && c <= 21'h00036F) || (c >= 21'h000483 && c <= 21'h000489) ||
            (c >= 21'h000591 && c <= 21'h0005C7) || (c >= 21'h000610 && c <= 21'h00061A) ||
            (c >= 21'h00064B && c <= 21'h00065F) || (c == 21'h000670) ||
            (c >= 21'h0006D6 && c <= 21'h0006ED) || (c >= 21'h000730 && c <= 21'h00074A) ||
            (c == 21'h000E31) || (c >= 21'h000E34 && c <= 21'h000E3A) ||
            (c == 21'h000EB1) || (c >= 21'h000EB4 && c <= 21'h000EBC) ||
            (c >= 21'h001AB0 && c <= 21'h001AFF) || (c >= 21'h001DC0 && c <= 21'h001DFF) ||
            (c >= 21'h0020D0 && c <= 21'h0020FF) || (c >= 21'h00FE20 && c <= 21'h00FE2F) ||
            (c >= 21'h00FE00 && c <= 21'h00FE0F) || (c >= 21'h0E0100 && c <= 21'h0E01EF) ||
            (c == 21'h00200C) || (c == ZWJ_CP) || (c == 21'h00034F);
      return hit;
   endfunction

   task restart_span();
      pend_bits  = '0;
      pend_count = '0;
      after_zwj  = 1'b0;
      span_fresh = 1'b1;
      char_pos   = '0;
   endtask

   task decode_byte(input req_payload_type item);
      logic [CODE_POINT_BITS-1:0] cp;
      logic                       got;
      logic [1:0]                 left;
      logic                       mark;
      logic                       joined;
      logic [1:0]                 step;
      logic [INDEX_BITS:0]        bumped;
      rsp_payload_type            want;
      cp  = '0;
      got = 1'b0;
      if (pend_count == 2'd0) begin
         if (!item.data_byte[7]) begin
            cp  = {13'd0, item.data_byte};
            got = 1'b1;
         end else if ((item.data_byte & LEAD2_MASK) == LEAD2_MATCH) begin
            pend_bits  = {10'd0, item.data_byte[4:0], 6'd0};
            pend_count = 2'd1;
         end else if ((item.data_byte & LEAD3_MASK) == LEAD3_MATCH) begin
            pend_bits  = {5'd0, item.data_byte[3:0], 12'd0};
            pend_count = 2'd2;
         end else if ((item.data_byte & LEAD4_MASK) == LEAD4_MATCH) begin
            pend_bits  = {item.data_byte[2:0], 18'd0};
            pend_count = 2'd3;
         end else begin
            cp  = REPLACEMENT_CP;
            got = 1'b1;
         end
      end else begin
         // Take any byte as a continuation; only its low six bits count
         left       = pend_count - 2'd1;
         pend_count = left;
         pend_bits  = pend_bits | (21'(item.data_byte[5:0]) << (6 * left));
         if (left == 2'd0) begin
            cp        = pend_bits;
            pend_bits = '0;
            got       = 1'b1;
         end
      end
      if (!got && item.span_end) begin
         cp  = REPLACEMENT_CP;
         got = 1'b1;
      end
      if (got) begin
         mark      = is_mark(cp);
         joined    = mark | after_zwj;
         after_zwj = (cp == ZWJ_CP);
         if (!joined && !span_fresh) begin
            step     = (cp >= SUPPLEMENTARY_BASE) ? 2'd2 : 2'd1;
            bumped   = {1'b0, char_pos} + (INDEX_BITS+1)'(step);
            char_pos = bumped[INDEX_BITS] ? '1 : bumped[INDEX_BITS-1:0];
         end
         span_fresh          = 1'b0;
         want.code_point     = cp;
         want.non_spacing    = mark;
         want.joins_previous = joined;
         want.char_index     = CHAR_INDEX_BITS'(char_pos);
         want.span_last      = item.span_end;
         code_points_due.insert(code_points_due.size(), want);
      end
      if (item.span_end) begin
         restart_span();
      end
   endtask

   task check_field(input string what, input logic [31:0] want, input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_span();
         code_points_due.delete();
         mismatches = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (code_points_due.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual code point 0x%0h",
                        $time, rsp_payload.code_point);
               mismatches++;
            end else begin
               oldest = code_points_due.pop_front();
               check_field("code_point", 32'(oldest.code_point), 32'(rsp_payload.code_point));
               check_field("non_spacing", 32'(oldest.non_spacing),
                           32'(rsp_payload.non_spacing));
               check_field("joins_previous", 32'(oldest.joins_previous),
                           32'(rsp_payload.joins_previous));
               check_field("char_index", 32'(oldest.char_index), 32'(rsp_payload.char_index));
               check_field("span_last", 32'(oldest.span_last), 32'(rsp_payload.span_last));
            end
         end
      end
      codes_due = code_points_due.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, receiver
// stalls and the verdict. Depends on u8ci_pkg, u8ci_if and u8ci_decode_checker.
`timescale 1ns / 100ps
module tb_top;
   import u8ci_pkg::*;

   localparam int PHASE_ITEMS = 220;

   logic clock;
   logic reset;
   int   snd_idle_pct;
   int   rcv_idle_pct;
   int   bytes_sent;
   int   mismatch_total;
   int   codes_due;
   int   drain_wait;

   u8ci_req_if req_chan();
   u8ci_rsp_if rsp_chan();

   utf8_cluster_indexer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   u8ci_decode_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .mismatches  (mismatch_total),
      .codes_due   (codes_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   // Call at a falling edge; returns at the falling edge after the item is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{data_byte: b, span_end: last};
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Encode cp in n bytes; keep > 0 cuts the sequence after keep bytes
   task automatic send_code(input logic [20:0] cp, input int n, input int keep,
                            input logic last);
      logic [7:0] seq [4];
      int         count;
      case (n)
         1:       seq[0] = {1'b0, cp[6:0]};
         2:       seq[0] = {3'b110, cp[10:6]};
         3:       seq[0] = {4'b1110, cp[15:12]};
         default: seq[0] = {5'b11110, cp[20:18]};
      endcase
      for (int k = 1; k < n; k++) begin
         seq[k] = {2'b10, 6'(cp >> (6 * (n - 1 - k)))};
      end
      count = (keep > 0) ? keep : n;
      for (int k = 0; k < count; k++) begin
         // Scramble the marker bits now and then; the block must ignore them
         if (k > 0 && $urandom_range(0, 9) == 0) begin
            seq[k][7:6] = 2'($urandom);
         end
         send_byte(seq[k], last && (k == count - 1));
      end
   endtask

   task automatic send_random_span();
      int          chars;
      int          kind;
      int          n;
      int          keep;
      logic [20:0] cp;
      logic        last;
      chars = $urandom_range(1, 10);
      for (int c = 0; c < chars; c++) begin
         last = (c == chars - 1);
         kind = $urandom_range(0, 99);
         keep = 0;
         n    = 1;
         cp   = '0;
         if (kind < 28) begin
            cp = 21'($urandom_range(0, 'h7F));
         end else if (kind < 42) begin
            cp = 21'($urandom_range(0, 'h7FF));
            n  = 2;
         end else if (kind < 56) begin
            cp = 21'($urandom_range(0, 'hFFFF));
            n  = 3;
         end else if (kind < 68) begin
            cp = 21'($urandom);
            n  = 4;
         end else if (kind < 82) begin
            case ($urandom_range(0, 4))
               0: begin cp = 21'($urandom_range('h300, 'h36F)); n = 2; end
               1: begin cp = 21'($urandom_range('hFE00, 'hFE0F)); n = 3; end
               2: begin cp = 21'($urandom_range('hE0100, 'hE01EF)); n = 4; end
               3: begin cp = 21'($urandom_range('h20D0, 'h20FF)); n = 3; end
               default: begin cp = 21'h00200C; n = 3; end
            endcase
         end else if (kind < 88) begin
            cp = ZWJ_CP;
            n  = 3;
         end else if (kind < 94) begin
            n = 0;
         end else begin
            cp   = 21'($urandom);
            n    = $urandom_range(2, 4);
            keep = $urandom_range(1, n - 1);
         end
         if (n == 0) begin
            send_byte(8'($urandom_range(0, 255)), last);
         end else begin
            send_code(cp, n, keep, last);
         end
      end
   endtask

   // Hold valid low until every result is back
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (codes_due != 0);
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      bytes_sent       = 0;
      snd_idle_pct     = 38;
      rcv_idle_pct     = 69;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ASCII extremes, combining mark, ZWJ then a joined letter, supplementary
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_code(21'h000301, 2, 0, 1'b0);
      send_code(ZWJ_CP, 3, 0, 1'b0);
      send_byte(8'h41, 1'b0);
      send_code(21'h01F600, 4, 0, 1'b0);
      send_code(21'h1FFFFF, 4, 0, 1'b1);
      // Invalid leads, a lead byte where a continuation belongs, a cut sequence
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h80, 1'b1);
      // Supplementary variation selector, then an invalid lead closing the span
      send_code(21'h0E0100, 4, 0, 1'b0);
      send_byte(8'hF8, 1'b1);

      while (bytes_sent < PHASE_ITEMS) send_random_span();
      hold_until_drained();

      snd_idle_pct = 69;
      rcv_idle_pct = 38;
      while (bytes_sent < 2 * PHASE_ITEMS) send_random_span();
      hold_until_drained();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      while (bytes_sent < 3 * PHASE_ITEMS) send_random_span();

      // Supplementary step mid-span, then a one-byte span right after the span ends
      send_byte(8'h61, 1'b0);
      send_code(SUPPLEMENTARY_BASE, 4, 0, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h43, 1'b1);
      send_byte(8'h44, 1'b1);

      req_chan.valid <= 1'b0;
      drain_wait = 0;
      while (codes_due != 0 && drain_wait < 5000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (10) @(negedge clock);
      if (mismatch_total == 0 && codes_due == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* files.f */
sv/u8ci_pkg.sv
sv/u8ci_if.sv
sv/u8ci_decode.sv
sv/u8ci_index.sv
sv/utf8_cluster_indexer.sv
sv/u8ci_checker.sv
tb/sv/u8ci_decode_checker.sv
tb/sv/tb_top.sv
